@@ rtl/sliding_window_median_top_assert.svh @@
// Assertion macros used by the checker of the sliding window median block.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SWM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SWM_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

@@ rtl/swm_pkg.sv @@
// Package with the shared constants and types of the sliding window median block.
package swm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int DOUT_W     = 33;
  localparam int OUT_TD_W   = 40;
  localparam int CFG_W      = 5;
  localparam int WINDOW_DEF = 16;
  localparam int LEN_RESET  = 16;

  // Control broadcast to every cell of the sorted row.
  typedef struct packed {
    logic                       upd;
    logic                       clr;
    logic                       rm_en;
    logic signed [SAMPLE_W-1:0] sample;
  } swm_ctrl_t;

  // Compacted view of one cell, handed to its right-hand neighbor.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] data;
    logic                       vld;
    logic                       le;
  } swm_link_t;

endpackage

@@ rtl/sliding_window_median_top.sv @@
// Top level of the sliding window median filter with its stream and configuration ports.
// The filter keeps the last window_length signed samples in a row of cells sorted in
// ascending order, each cell tagged with the sample's age. Once the window is full,
// every accepted sample evicts the cell whose age marks it as the oldest, is inserted
// at its sorted place, and the filter returns twice the median of the window; samples
// that only fill the window produce no result. The whole row updates in the clock edge
// that accepts a sample, so one sample per clock is taken as long as results are being
// taken; a result reaches out_tvalid at the clock edge right after the one that accepted
// its sample (the accepting edge updates the row, the next edge selects and adds the
// median into the output register), later only while a stalled result still holds the
// output register. Writing window_length empties the window, and the next window_length
// samples refill it. No clearing pass follows reset: the cells come up empty at once.
module sliding_window_median_top #(
  parameter int WINDOW = swm_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream, tdata[31:0] = sample.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [swm_pkg::SAMPLE_W-1:0]     in_tdata,
  // Result stream, tdata[32:0] = doubled_median, tdata[39:33] = zero.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [swm_pkg::OUT_TD_W-1:0]     out_tdata,
  // Configuration write, data[4:0] = window_length.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]        cfg_data
);
  import swm_pkg::*;

  localparam int LEN_W   = $clog2(WINDOW + 1);
  localparam int AGE_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CMP_W   = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int LEN_RST = (LEN_RESET < WINDOW) ? LEN_RESET : WINDOW;

  // Effective window length, already clamped into one to WINDOW.
  logic [LEN_W-1:0]      eff_len_r, eff_len_nxt;
  logic [LEN_W-1:0]      fill_cnt_r, fill_cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [DOUT_W-1:0]     median_r, median_nxt;

  logic                  in_acc;
  logic                  cfg_acc;
  logic                  full;
  logic                  out_load;
  logic [CMP_W-1:0]      cfg_wide;
  logic [LEN_W-1:0]      len_m1;
  logic [LEN_W-1:0]      half;
  logic [AGE_W-1:0]      half_idx;
  logic [AGE_W-1:0]      half_m1_idx;
  swm_ctrl_t             ctrl;

  swm_link_t                  lnk      [WINDOW+1];
  logic [AGE_W-1:0]           lnk_age  [WINDOW+1];
  logic                       rm_chain [WINDOW+1];
  logic signed [SAMPLE_W-1:0] cell_data [WINDOW+1];
  logic [AGE_W-1:0]           cell_age  [WINDOW+1];
  logic                       cell_vld  [WINDOW+1];

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (fill_cnt_r == eff_len_r);

  // The result stage frees up when the output register is empty or is being taken.
  assign out_load  = pend_r && (!out_vld_r || out_tready);
  assign in_tready = !pend_r || out_load;

  assign len_m1 = eff_len_r - LEN_W'(1);

  always_comb begin
    ctrl.upd    = in_acc;
    ctrl.clr    = cfg_acc;
    ctrl.rm_en  = full;
    ctrl.sample = signed'(in_tdata);
  end

  // Cell zero always takes the new sample when nothing smaller or equal precedes it.
  assign lnk[0].data = '0;
  assign lnk[0].vld  = 1'b1;
  assign lnk[0].le   = 1'b1;
  assign lnk_age[0]  = '0;
  assign rm_chain[0] = 1'b0;

  // Past the last cell nothing is held.
  assign cell_data[WINDOW] = '0;
  assign cell_age[WINDOW]  = '0;
  assign cell_vld[WINDOW]  = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swm_cell #(
      .AGE_W (AGE_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .age_lim     (len_m1[AGE_W-1:0]),
      .left_lnk    (lnk[i]),
      .left_age    (lnk_age[i]),
      .right_data  (cell_data[i+1]),
      .right_age   (cell_age[i+1]),
      .right_vld   (cell_vld[i+1]),
      .rm_seen_in  (rm_chain[i]),
      .rm_seen_out (rm_chain[i+1]),
      .own_lnk     (lnk[i+1]),
      .own_age     (lnk_age[i+1]),
      .data_o      (cell_data[i]),
      .age_o       (cell_age[i]),
      .vld_o       (cell_vld[i])
    );
  end

  // The median sits at fixed places of the sorted row once the window is full.
  assign half        = eff_len_r >> 1;
  assign half_idx    = half[AGE_W-1:0];
  assign half_m1_idx = half_idx - AGE_W'(1);

  always_comb begin
    if (eff_len_r[0]) begin
      median_nxt = {cell_data[half_idx], 1'b0};
    end else begin
      median_nxt = {cell_data[half_m1_idx][SAMPLE_W-1], cell_data[half_m1_idx]}
                 + {cell_data[half_idx][SAMPLE_W-1], cell_data[half_idx]};
    end
  end

  always_comb begin
    cfg_wide    = CMP_W'(cfg_data);
    eff_len_nxt = eff_len_r;
    if (cfg_acc) begin
      if (cfg_wide == '0) begin
        eff_len_nxt = LEN_W'(1);
      end else if (cfg_wide > CMP_W'(WINDOW)) begin
        eff_len_nxt = LEN_W'(WINDOW);
      end else begin
        eff_len_nxt = cfg_wide[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    if (cfg_acc) begin
      fill_cnt_nxt = '0;
    end else if (in_acc && !full) begin
      fill_cnt_nxt = fill_cnt_r + LEN_W'(1);
    end
  end

  // A transaction on a full window leaves a median to be picked up from the row.
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc) begin
      pend_nxt = full;
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_len_r  <= LEN_W'(LEN_RST);
      fill_cnt_r <= '0;
      pend_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      eff_len_r  <= eff_len_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      pend_r     <= pend_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median_r <= median_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TD_W - DOUT_W){1'b0}}, median_r};

endmodule

@@ rtl/swm_cell.sv @@
// One cell of the sorted row: holds a sample, its age and a valid bit.
module swm_cell #(
  parameter int AGE_W = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swm_pkg::swm_ctrl_t                 ctrl,
  input  logic [AGE_W-1:0]                   age_lim,
  input  swm_pkg::swm_link_t                 left_lnk,
  input  logic [AGE_W-1:0]                   left_age,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] right_data,
  input  logic [AGE_W-1:0]                   right_age,
  input  logic                               right_vld,
  input  logic                               rm_seen_in,
  output logic                               rm_seen_out,
  output swm_pkg::swm_link_t                 own_lnk,
  output logic [AGE_W-1:0]                   own_age,
  output logic signed [swm_pkg::SAMPLE_W-1:0] data_o,
  output logic [AGE_W-1:0]                   age_o,
  output logic                               vld_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] data_r, data_nxt;
  logic [AGE_W-1:0]           age_r, age_nxt;
  logic                       vld_r, vld_nxt;
  logic                       rm;
  logic                       shifted;

  // This cell drops its sample when it holds the oldest one of a full window.
  assign rm          = ctrl.rm_en && vld_r && (age_r == age_lim);
  assign shifted     = rm_seen_in | rm;
  assign rm_seen_out = shifted;

  // Row with the evicted sample squeezed out, as seen at this position.
  always_comb begin
    own_lnk.data = shifted ? right_data : data_r;
    own_lnk.vld  = shifted ? right_vld  : vld_r;
    own_age      = shifted ? right_age  : age_r;
    own_lnk.le   = own_lnk.vld && (own_lnk.data <= ctrl.sample);
  end

  always_comb begin
    data_nxt = data_r;
    age_nxt  = age_r;
    vld_nxt  = vld_r;
    if (ctrl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctrl.upd) begin
      vld_nxt = left_lnk.vld;
      if (own_lnk.le) begin
        data_nxt = own_lnk.data;
        age_nxt  = own_age + AGE_W'(1);
      end else if (left_lnk.le) begin
        data_nxt = ctrl.sample;
        age_nxt  = '0;
      end else begin
        data_nxt = left_lnk.data;
        age_nxt  = left_age + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    age_r  <= age_nxt;
  end

  assign data_o = data_r;
  assign age_o  = age_r;
  assign vld_o  = vld_r;

endmodule

@@ rtl/swm_chk.sv @@
// Port-level checker for the sliding window median block, bound to its top level.
`include "sliding_window_median_top_assert.svh"

module swm_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [swm_pkg::OUT_TD_W-1:0] out_tdata,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);
  import swm_pkg::*;

  // A stalled result keeps its value.
  `SWM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The padding above the result is always zero.
  `SWM_ASSERT_SAME(a_out_pad, out_tvalid, out_tdata[OUT_TD_W-1:DOUT_W] == '0)

  // Configuration writes are never back-pressured.
  `SWM_ASSERT_SAME(a_cfg_rdy, cfg_valid, cfg_ready)

  // Reset leaves no result pending and the input open.
  `SWM_ASSERT_NEXT_RST(a_rst_idle, !rst_n, !out_tvalid && in_tready)

  // A waiting result with a stalled output blocks a second one behind it.
  `SWM_ASSERT_NEXT(a_no_overrun, out_tvalid && !out_tready && in_tvalid && in_tready,
                   !in_tready || out_tvalid)

endmodule

bind sliding_window_median_top swm_chk u_swm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
